// ----- rtl/hsk_pkg.sv -----
// Shared types and op codes for the heap sort by key unit.
package hsk_pkg;

    localparam int KEY_W = 32;
    localparam int TAG_W = 16;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last;
    } t_in_rec;

    typedef struct packed {
        logic [KEY_W-1:0] key_res;
        logic [TAG_W-1:0] tag_res;
        logic             last_res;
        logic             overflow;
    } t_out_rec;

    // Datapath operations issued by the controller, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_BLD_INIT,
        OP_BLD_RD,
        OP_BLD_LD,
        OP_SIFT_RD,
        OP_SIFT_CMP,
        OP_EXT_INIT,
        OP_EXT_RD,
        OP_EXT_SWAP,
        OP_EMIT_INIT,
        OP_EMIT_RD,
        OP_EMIT_LD,
        OP_EMIT_NEXT,
        OP_CLEAR
    } t_dp_op;

    // Datapath status back to the controller
    typedef struct packed {
        logic iter_zero;
        logic iter_le1;
        logic sift_done;
        logic out_last;
    } t_dp_stat;

endpackage

// ----- rtl/hsk_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module hsk_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write and read; reads return the old contents on a collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- rtl/hsk_dpath.sv -----
// Datapath: record RAM, count, sift registers and output register.
module hsk_dpath
    import hsk_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_op   i_op,
    input  t_in_rec  i_in_data,
    output t_out_rec o_out_data,
    output t_dp_stat o_stat
);

    localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int RW = KW + TAG_W;
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = IW + 2;

    logic [CW-1:0]  r_count, n_count;
    logic           r_drop, n_drop;
    logic [CW-1:0]  r_iter, n_iter;
    logic [CW-1:0]  r_size, n_size;
    logic [IW-1:0]  r_node, n_node;
    logic [KW-1:0]  r_ekey, n_ekey;
    logic [TAG_W-1:0] r_etag, n_etag;
    t_out_rec       r_out, n_out;

    logic           w_we;
    logic [IW-1:0]  w_waddr;
    logic [RW-1:0]  w_wdata;
    logic [IW-1:0]  w_raddr_a;
    logic [IW-1:0]  w_raddr_b;
    logic [RW-1:0]  w_rdata_a;
    logic [RW-1:0]  w_rdata_b;

    logic [KW-1:0]    w_a_key, w_b_key, w_big_key;
    logic [TAG_W-1:0] w_a_tag, w_b_tag;
    logic [LW-1:0]    w_lc, w_rc, w_child_idx;
    logic             w_lc_ok, w_rc_ok, w_a_gt, w_b_gt, w_sift_done, w_full;
    logic [CW-1:0]    w_iter_m1;
    logic [RW-1:0]    w_child;

    hsk_ram #(
        .WIDTH (RW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    // Split read data and compare the children against the sifted record
    always_comb begin
        w_a_key     = w_rdata_a[RW-1 -: KW];
        w_a_tag     = w_rdata_a[TAG_W-1:0];
        w_b_key     = w_rdata_b[RW-1 -: KW];
        w_b_tag     = w_rdata_b[TAG_W-1:0];
        w_lc        = {1'b0, r_node, 1'b1};
        w_rc        = w_lc + 1'b1;
        w_lc_ok     = w_lc < LW'(r_size);
        w_rc_ok     = w_rc < LW'(r_size);
        w_a_gt      = w_lc_ok && (w_a_key > r_ekey);
        w_big_key   = w_a_gt ? w_a_key : r_ekey;
        w_b_gt      = w_rc_ok && (w_b_key > w_big_key);
        w_sift_done = !w_a_gt && !w_b_gt;
        w_child     = w_b_gt ? w_rdata_b : w_rdata_a;
        w_child_idx = w_b_gt ? w_rc : w_lc;
        w_iter_m1   = r_iter - 1'b1;
        w_full      = r_count == CW'(CAPACITY);
    end

    // Decode the current operation
    always_comb begin
        n_count   = r_count;
        n_drop    = r_drop;
        n_iter    = r_iter;
        n_size    = r_size;
        n_node    = r_node;
        n_ekey    = r_ekey;
        n_etag    = r_etag;
        n_out     = r_out;
        w_we      = 1'b0;
        w_waddr   = r_node;
        w_wdata   = {r_ekey, r_etag};
        w_raddr_a = '0;
        w_raddr_b = '0;
        case (i_op)
            OP_LOAD: begin
                if (!w_full) begin
                    w_we    = 1'b1;
                    w_waddr = r_count[IW-1:0];
                    w_wdata = {i_in_data.key[KW-1:0], i_in_data.tag};
                    n_count = r_count + 1'b1;
                end else begin
                    n_drop = 1'b1;
                end
            end
            OP_BLD_INIT: begin
                n_iter = r_count >> 1;
            end
            OP_BLD_RD: begin
                w_raddr_a = w_iter_m1[IW-1:0];
                n_node    = w_iter_m1[IW-1:0];
                n_size    = r_count;
            end
            OP_BLD_LD: begin
                n_ekey = w_a_key;
                n_etag = w_a_tag;
            end
            OP_SIFT_RD: begin
                w_raddr_a = w_lc[IW-1:0];
                w_raddr_b = w_rc[IW-1:0];
            end
            OP_SIFT_CMP: begin
                // Drop the record into the hole, or pull the larger child up
                w_we    = 1'b1;
                w_waddr = r_node;
                if (w_sift_done) begin
                    w_wdata = {r_ekey, r_etag};
                    n_iter  = w_iter_m1;
                end else begin
                    w_wdata = w_child;
                    n_node  = w_child_idx[IW-1:0];
                end
            end
            OP_EXT_INIT: begin
                n_iter = r_count;
            end
            OP_EXT_RD: begin
                w_raddr_a = '0;
                w_raddr_b = w_iter_m1[IW-1:0];
            end
            OP_EXT_SWAP: begin
                // Move the root to the heap end, sift the old end from the root
                w_we    = 1'b1;
                w_waddr = w_iter_m1[IW-1:0];
                w_wdata = w_rdata_a;
                n_ekey  = w_b_key;
                n_etag  = w_b_tag;
                n_node  = '0;
                n_size  = w_iter_m1;
            end
            OP_EMIT_INIT: begin
                n_iter = '0;
            end
            OP_EMIT_RD: begin
                w_raddr_a = r_iter[IW-1:0];
            end
            OP_EMIT_LD: begin
                n_out.key_res  = KEY_W'(w_a_key);
                n_out.tag_res  = w_a_tag;
                n_out.last_res = ((CW+1)'(r_iter) + 1'b1) == (CW+1)'(r_count);
                n_out.overflow = r_drop;
            end
            OP_EMIT_NEXT: begin
                n_iter = r_iter + 1'b1;
            end
            OP_CLEAR: begin
                n_count = '0;
                n_drop  = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Hold control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
            r_iter  <= '0;
        end else begin
            r_count <= n_count;
            r_drop  <= n_drop;
            r_iter  <= n_iter;
        end
    end

    // Hold payload registers
    always_ff @(posedge i_clk) begin
        r_size <= n_size;
        r_node <= n_node;
        r_ekey <= n_ekey;
        r_etag <= n_etag;
        r_out  <= n_out;
    end

    assign o_out_data       = r_out;
    assign o_stat.iter_zero = r_iter == '0;
    assign o_stat.iter_le1  = r_iter <= CW'(1);
    assign o_stat.sift_done = w_sift_done;
    assign o_stat.out_last  = r_out.last_res;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("record count beyond capacity");

    a_sift_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == OP_SIFT_CMP |-> (CW'(r_node) < r_size))
        else $error("sift node outside the heap");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == OP_CLEAR |=> (r_count == '0) && !r_drop)
        else $error("set not cleared after last transfer");

endmodule

// ----- rtl/hsk_ctrl.sv -----
// Controller: sequences load, heap build, extraction and emission.
module hsk_ctrl
    import hsk_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_last,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_op   o_op,
    output logic     o_in_ready,
    output logic     o_out_valid
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_BLD_INIT,
        S_BLD_CHK,
        S_BLD_RD,
        S_BLD_LD,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_EXT_CHK,
        S_EXT_RD,
        S_EXT_SWAP,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } t_state;

    t_state r_state, n_state;
    logic   r_extract, n_extract;
    logic   r_in_ready, n_in_ready;
    logic   r_out_valid, n_out_valid;

    // Next state and datapath operation
    always_comb begin
        n_state   = r_state;
        n_extract = r_extract;
        o_op      = OP_NONE;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid && r_in_ready) begin
                    o_op = OP_LOAD;
                    if (i_in_last) begin
                        n_state = S_BLD_INIT;
                    end
                end
            end
            S_BLD_INIT: begin
                o_op      = OP_BLD_INIT;
                n_extract = 1'b0;
                n_state   = S_BLD_CHK;
            end
            S_BLD_CHK: begin
                if (i_stat.iter_zero) begin
                    o_op      = OP_EXT_INIT;
                    n_extract = 1'b1;
                    n_state   = S_EXT_CHK;
                end else begin
                    n_state = S_BLD_RD;
                end
            end
            S_BLD_RD: begin
                o_op    = OP_BLD_RD;
                n_state = S_BLD_LD;
            end
            S_BLD_LD: begin
                o_op    = OP_BLD_LD;
                n_state = S_SIFT_RD;
            end
            S_SIFT_RD: begin
                o_op    = OP_SIFT_RD;
                n_state = S_SIFT_CMP;
            end
            S_SIFT_CMP: begin
                o_op = OP_SIFT_CMP;
                if (i_stat.sift_done) begin
                    n_state = r_extract ? S_EXT_CHK : S_BLD_CHK;
                end else begin
                    n_state = S_SIFT_RD;
                end
            end
            S_EXT_CHK: begin
                if (i_stat.iter_le1) begin
                    o_op    = OP_EMIT_INIT;
                    n_state = S_EMIT_RD;
                end else begin
                    n_state = S_EXT_RD;
                end
            end
            S_EXT_RD: begin
                o_op    = OP_EXT_RD;
                n_state = S_EXT_SWAP;
            end
            S_EXT_SWAP: begin
                o_op    = OP_EXT_SWAP;
                n_state = S_SIFT_RD;
            end
            S_EMIT_RD: begin
                o_op    = OP_EMIT_RD;
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                o_op    = OP_EMIT_LD;
                n_state = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (r_out_valid && i_out_ready) begin
                    if (i_stat.out_last) begin
                        o_op    = OP_CLEAR;
                        n_state = S_LOAD;
                    end else begin
                        o_op    = OP_EMIT_NEXT;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
        n_in_ready  = n_state == S_LOAD;
        n_out_valid = n_state == S_EMIT_WAIT;
    end

    // Hold state and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_extract   <= 1'b0;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_extract   <= n_extract;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_ready && r_out_valid))
        else $error("input and output channels active together");

    a_back_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_ready && i_stat.out_last) |=> r_in_ready)
        else $error("no return to loading after the final transfer");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("output valid dropped before the transfer");

endmodule

// ----- rtl/heap_sort_by_key_unit.sv -----
// Heap sort by key unit: collects records, heapsorts them, emits ascending.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) carries records of key,
// tag and last. Each accepted record goes to the next free slot of the record
// RAM; once CAPACITY records are held, further records are dropped and every
// result of that set carries overflow. The record marked last closes the set
// and starts the sort; the input stays not ready until the whole sorted run
// has been transferred.
// The sort builds a max-heap and then extracts it. Each sift visits its levels with
// a RAM read of both children, then a compare and write back, including the level
// where it stops, after a setup of check, read and load for a build step, or of
// check, read and swap for an extraction step. Emission reads, loads and transfers
// each record, the transfer waiting for the receiver.
// Output channel (o_out_valid / i_out_ready / o_out_data) holds each result in
// an output register; a stalled receiver just holds the block in emission.
// Reset returns to loading with an empty store; RAM contents are not cleared.
module heap_sort_by_key_unit
    import hsk_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_rec  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_rec o_out_data
);

    t_dp_op   w_op;
    t_dp_stat w_stat;

    hsk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_data.last),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_op        (w_op),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    hsk_dpath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data),
        .o_stat     (w_stat)
    );

endmodule

// ----- tb/heap_sort_by_key_unit_test.sv -----
// Self-checking testbench for the heap sort by key unit: directed sets, then random sets.
`timescale 1ns / 1ps

module heap_sort_by_key_unit_test;
    import hsk_pkg::*;

    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS = 190;
    localparam int QUIET_AFTER = 165;
    localparam int DIR_ROWS = 17;
    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : ((KEY_W'(1) << KEY_BITS) - KEY_W'(1));
    localparam t_out_rec NO_RES = '0;

    // Key value mixes for random sets
    typedef enum int {
        KM_SPREAD,
        KM_TIES,
        KM_EDGES
    } t_key_mix;

    typedef struct {
        t_in_rec  rec;
        bit       typed;
        t_out_rec res;
    } t_dir_row;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     o_in_ready;
    t_in_rec  in_data = '0;
    logic     o_out_valid;
    logic     out_ready = 1'b0;
    t_out_rec o_out_data;

    // Heap image of the stored records, kept alongside the block
    logic [KEY_W-1:0] hs_key [CAPACITY];
    logic [TAG_W-1:0] hs_tag [CAPACITY];
    int unsigned      hs_count = 0;
    bit               hs_dropped = 1'b0;

    t_out_rec    sorted_due [$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned stall_left = 0;
    bit          quiet = 1'b0;

    // Single-record sets have their result typed in; the rest go through the heap image
    t_dir_row dir_tab [DIR_ROWS] = '{
        '{'{32'hFFFF_FFFF, 16'hFFFF, 1'b1}, 1'b1, '{32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0}},
        '{'{32'h0000_0000, 16'h0000, 1'b1}, 1'b1, '{32'h0000_0000, 16'h0000, 1'b1, 1'b0}},
        '{'{32'hAAAA_5555, 16'h5A5A, 1'b1}, 1'b1, '{32'hAAAA_5555, 16'h5A5A, 1'b1, 1'b0}},
        '{'{32'h0000_0007, 16'h0001, 1'b0}, 1'b0, NO_RES},
        '{'{32'h0000_0007, 16'h0002, 1'b0}, 1'b0, NO_RES},
        '{'{32'h0000_0000, 16'h0003, 1'b0}, 1'b0, NO_RES},
        '{'{32'hFFFF_FFFF, 16'h0004, 1'b0}, 1'b0, NO_RES},
        '{'{32'h0000_0007, 16'h0005, 1'b1}, 1'b0, NO_RES},
        '{'{32'h8000_0000, 16'h1234, 1'b0}, 1'b0, NO_RES},
        '{'{32'h7FFF_FFFF, 16'h4321, 1'b1}, 1'b0, NO_RES},
        '{'{32'h0000_0000, 16'hA001, 1'b0}, 1'b0, NO_RES},
        '{'{32'h0000_0000, 16'hA002, 1'b0}, 1'b0, NO_RES},
        '{'{32'h0000_0001, 16'hA003, 1'b0}, 1'b0, NO_RES},
        '{'{32'h0000_0002, 16'hA004, 1'b0}, 1'b0, NO_RES},
        '{'{32'hFFFF_FFFE, 16'hA005, 1'b0}, 1'b0, NO_RES},
        '{'{32'hFFFF_FFFF, 16'hA006, 1'b0}, 1'b0, NO_RES},
        '{'{32'hFFFF_FFFF, 16'hA007, 1'b1}, 1'b0, NO_RES}
    };

    heap_sort_by_key_unit #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void heap_swap(input int unsigned a, input int unsigned b);
        logic [KEY_W-1:0] k;
        logic [TAG_W-1:0] t;
        k = hs_key[a];
        t = hs_tag[a];
        hs_key[a] = hs_key[b];
        hs_tag[a] = hs_tag[b];
        hs_key[b] = k;
        hs_tag[b] = t;
    endfunction

    // Push a node down until neither child is strictly larger; left child first
    function automatic void sift_down(input int unsigned heap_len, input int unsigned root);
        int unsigned node;
        int unsigned big;
        int unsigned lc;
        int unsigned rc;
        node = root;
        forever begin
            big = node;
            lc = 2 * node + 1;
            rc = 2 * node + 2;
            if (lc < heap_len && hs_key[lc] > hs_key[big]) big = lc;
            if (rc < heap_len && hs_key[rc] > hs_key[big]) big = rc;
            if (big == node) return;
            heap_swap(node, big);
            node = big;
        end
    endfunction

    // Append one expected result to the tail of the queue
    function automatic void queue_result(input t_out_rec r);
        sorted_due = {sorted_due, r};
    endfunction

    // Store one record; on the closing record heapsort the set and queue the sorted run
    function automatic void absorb_record(input t_in_rec r, input bit queue_run);
        int unsigned n;
        int unsigned i;
        t_out_rec res;
        if (hs_count < CAPACITY) begin
            hs_key[hs_count] = r.key & KEY_MASK;
            hs_tag[hs_count] = r.tag;
            hs_count++;
        end else begin
            hs_dropped = 1'b1;
        end
        if (!r.last) return;
        n = hs_count;
        for (i = n / 2; i > 0; i--) sift_down(n, i - 1);
        for (i = n; i > 1; i--) begin
            heap_swap(0, i - 1);
            sift_down(i - 1, 0);
        end
        if (queue_run) begin
            for (i = 0; i < n; i++) begin
                res.key_res  = hs_key[i];
                res.tag_res  = hs_tag[i];
                res.last_res = (i + 1 == n);
                res.overflow = hs_dropped;
                queue_result(res);
            end
        end
        hs_count = 0;
        hs_dropped = 1'b0;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(input t_key_mix mix);
        case (mix)
            KM_TIES: return KEY_W'($urandom_range(0, 3));
            KM_EDGES: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return KEY_W'(1);
                    2: return {KEY_W{1'b1}} - KEY_W'(1);
                    default: return {KEY_W{1'b1}};
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        if (quiet || $urandom_range(0, 4) != 0) return 0;
        return $urandom_range(1, 18);
    endfunction

    // Present one record, optionally after an idle gap, and hold it until the transfer
    task automatic send_item(input t_in_rec r, input int unsigned gap);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Hold the sender off until the sorted run in flight has fully drained
    task automatic drain_runs();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (sorted_due.size() != 0);
    endtask

    function automatic void check_field(input string fld, input logic [KEY_W-1:0] want,
                                        input logic [KEY_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, want, got);
            mismatches++;
        end
    endfunction

    // Check each result transfer and drive receiver stalls
    always @(posedge i_clk) begin : rx_side
        t_out_rec want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (sorted_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_out_data);
                mismatches++;
            end else begin
                want = sorted_due.pop_front();
                check_field("key_res", want.key_res, o_out_data.key_res);
                check_field("tag_res", KEY_W'(want.tag_res), KEY_W'(o_out_data.tag_res));
                check_field("last_res", KEY_W'(want.last_res), KEY_W'(o_out_data.last_res));
                check_field("overflow", KEY_W'(want.overflow), KEY_W'(o_out_data.overflow));
            end
        end
        if (quiet) begin
            out_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 17);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        t_in_rec     rec;
        t_key_mix    mix;
        int unsigned row;
        int unsigned set_idx;
        int unsigned set_len;
        int unsigned j;
        int unsigned sent;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sets: single records at the extremes, ties, descending, duplicated ends
        for (row = 0; row < DIR_ROWS; row++) begin
            send_item(dir_tab[row].rec, pick_gap());
            absorb_record(dir_tab[row].rec, !dir_tab[row].typed);
            if (dir_tab[row].typed) queue_result(dir_tab[row].res);
        end
        drain_runs();

        // Random sets: a full store, an overflowing one, then mostly short sets
        sent = 0;
        set_idx = 0;
        while (sent < RAND_ITEMS) begin
            if (set_idx == 0) set_len = CAPACITY;
            else if (set_idx == 1) set_len = $urandom_range(CAPACITY + 1, CAPACITY + 4);
            else if ($urandom_range(0, 15) == 0) set_len = $urandom_range(20, 40);
            else set_len = $urandom_range(1, 10);
            mix = t_key_mix'($urandom_range(0, 2));
            for (j = 0; j < set_len; j++) begin
                rec.key  = pick_key(mix);
                rec.tag  = TAG_W'($urandom);
                rec.last = (j + 1 == set_len);
                quiet = (sent >= QUIET_AFTER);
                send_item(rec, pick_gap());
                absorb_record(rec, 1'b1);
                sent++;
            end
            if (set_idx == 1) drain_runs();
            set_idx++;
        end
        in_valid <= 1'b0;

        // Let the last run finish, then a short tail for stray results
        while (sorted_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatches == 0 && sorted_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
